[hdl/ilp_pkg.sv]
// shared constants and tables of the integer literal parser
package ilp_pkg;

    localparam int VALUE_BITS = 64;
    localparam int OUT_BITS   = 64;
    localparam int WIDE_BITS  = VALUE_BITS + 4;

    typedef logic [VALUE_BITS-1:0] acc_t;
    typedef logic [WIDE_BITS-1:0]  wide_t;

    // token phases
    localparam logic [1:0] PH_START      = 2'd0;
    localparam logic [1:0] PH_VALUE      = 2'd1;
    localparam logic [1:0] PH_AFTER_SPEC = 2'd2;
    localparam logic [1:0] PH_SUFFIX     = 2'd3;

    // radix classes
    localparam logic [1:0] RAD_DEC = 2'd0;
    localparam logic [1:0] RAD_HEX = 2'd1;
    localparam logic [1:0] RAD_BIN = 2'd2;
    localparam logic [1:0] RAD_OCT = 2'd3;

    // suffix letters
    localparam logic [1:0] SFX_NONE = 2'd0;
    localparam logic [1:0] SFX_I    = 2'd1;
    localparam logic [1:0] SFX_U    = 2'd2;
    localparam logic [1:0] SFX_F    = 2'd3;

    // width indexes: 8 .. 512, then none
    localparam logic [2:0] W_8    = 3'd0;
    localparam logic [2:0] W_16   = 3'd1;
    localparam logic [2:0] W_32   = 3'd2;
    localparam logic [2:0] W_64   = 3'd3;
    localparam logic [2:0] W_128  = 3'd4;
    localparam logic [2:0] W_256  = 3'd5;
    localparam logic [2:0] W_512  = 3'd6;
    localparam logic [2:0] W_NONE = 3'd7;

    localparam logic [9:0] BAD_DIGITS = 10'd1023;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SFX   = 3'd1;
    localparam logic [2:0] ST_TOO_LONG  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_NOT_IMPL  = 3'd4;
    localparam logic [2:0] ST_MALFORMED = 3'd5;

    // type codes
    localparam logic [3:0] TY_I32 = 4'd0;
    localparam logic [3:0] TY_I64 = 4'd1;
    localparam logic [3:0] TY_I8  = 4'd2;
    localparam logic [3:0] TY_I16 = 4'd3;
    localparam logic [3:0] TY_U8  = 4'd4;
    localparam logic [3:0] TY_U16 = 4'd5;
    localparam logic [3:0] TY_U32 = 4'd6;
    localparam logic [3:0] TY_U64 = 4'd7;
    localparam logic [3:0] TY_F32 = 4'd8;
    localparam logic [3:0] TY_F64 = 4'd9;

    localparam logic [7:0] LIMIT_RESET = 8'd255;

    // raw character limit per radix and width index
    function automatic logic [9:0] len_limit(input logic [1:0] rad, input logic [2:0] widx);
        logic [9:0] lim;
        lim = 10'd0;
        unique case (rad)
            RAD_DEC:
            begin
                unique case (widx)
                    W_8:     lim = 10'd3;
                    W_16:    lim = 10'd5;
                    W_32:    lim = 10'd10;
                    W_64:    lim = 10'd20;
                    W_128:   lim = 10'd39;
                    W_256:   lim = 10'd78;
                    W_512:   lim = 10'd155;
                    default: lim = 10'd20;
                endcase
            end
            RAD_HEX:
            begin
                unique case (widx)
                    W_8:     lim = 10'd2;
                    W_16:    lim = 10'd4;
                    W_32:    lim = 10'd8;
                    W_64:    lim = 10'd16;
                    W_128:   lim = 10'd32;
                    W_256:   lim = 10'd64;
                    W_512:   lim = 10'd128;
                    default: lim = 10'd16;
                endcase
            end
            RAD_BIN:
            begin
                unique case (widx)
                    W_8:     lim = 10'd8;
                    W_16:    lim = 10'd16;
                    W_32:    lim = 10'd32;
                    W_64:    lim = 10'd64;
                    W_128:   lim = 10'd128;
                    W_256:   lim = 10'd256;
                    W_512:   lim = 10'd512;
                    default: lim = 10'd64;
                endcase
            end
            default:
            begin
                unique case (widx)
                    W_8:     lim = 10'd3;
                    W_16:    lim = 10'd8;
                    W_32:    lim = 10'd11;
                    default: lim = 10'd22;
                endcase
            end
        endcase
        return lim;
    endfunction

endpackage

[hdl/integer_literal_parser.sv]
// integer literal parser: characters of a numeric token in, one converted value out
//
// Input channel (in_valid / in_stall): one ASCII character per request with its
// radix class and a last_char mark. The radix class of a token's first character
// holds for the whole token. Output channel (out_valid / out_stall): one request
// per token, sent for the character marked last, carrying value, type_code and
// status. Value and type_code are zero on any error status.
// Configuration (cfg_valid / cfg_ready / value_length_limit): cfg_ready is always
// high; write only while no token is in flight.
// Timing: a character is held in the input register, then the token state
// is updated and, on the last character, the result register loaded. One
// character is taken every cycle unless a last character waits in the input
// register behind a stalled result; the per-character shift-add of the
// accumulator is the longest path.
// When the receiver stalls, the result register holds and the input side keeps
// taking characters until another last character reaches the input register.
// Reset clears the token state, both valid flags, and sets the limit to 255.
module integer_literal_parser
    import ilp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           character,
    input  logic [1:0]           radix_class,
    input  logic                 last_char,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OUT_BITS-1:0]  value,
    output logic [3:0]           type_code,
    output logic [2:0]           status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           value_length_limit
);

    localparam acc_t MASK = '1;
    localparam acc_t SMAX = MASK >> 1;

    // input register
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic [1:0] rad_in_reg;
    logic       last_reg;

    // token state
    logic [1:0] phase_reg,  phase_next;
    acc_t       acc_reg,    acc_next;
    logic       ovf_reg,    ovf_next;
    logic [7:0] raw_reg,    raw_next;
    logic       fz_reg,     fz_next;
    logic       prefix_reg, prefix_next;
    logic       specp_reg,  specp_next;
    logic       specs_reg,  specs_next;
    logic [1:0] letter_reg, letter_next;
    logic [9:0] sdig_reg,   sdig_next;
    logic [1:0] scount_reg, scount_next;
    logic       malf_reg,   malf_next;
    logic [1:0] radix_reg,  radix_next;

    logic [7:0] limit_reg;

    // result register
    logic                out_valid_reg;
    logic [OUT_BITS-1:0] value_reg,  value_next;
    logic [3:0]          type_reg,   type_next;
    logic [2:0]          status_reg, status_next;

    logic advance;
    logic accept;

    assign advance   = in_valid_reg && (!last_reg || !out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // character decode and state update
    logic [1:0] sl;
    logic       is_dec, is_lo, is_up;
    logic [3:0] dval;
    logic       dig_ok;
    wide_t      wide;
    logic       is_c;

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        raw_next    = raw_reg;
        fz_next     = fz_reg;
        prefix_next = prefix_reg;
        specp_next  = specp_reg;
        specs_next  = specs_reg;
        letter_next = letter_reg;
        sdig_next   = sdig_reg;
        scount_next = scount_reg;
        malf_next   = malf_reg;
        radix_next  = radix_reg;
        sl          = SFX_NONE;
        dval        = 4'd0;
        dig_ok      = 1'b0;
        wide        = '0;
        is_c        = 1'b0;

        if (phase_reg == PH_START)
        begin
            radix_next = rad_in_reg;
            phase_next = PH_VALUE;
        end

        case (char_reg)
            "i", "I": sl = SFX_I;
            "u", "U": sl = SFX_U;
            "p", "P": sl = (radix_next == RAD_HEX) ? SFX_F : SFX_NONE;
            "f", "F": sl = (radix_next == RAD_BIN || radix_next == RAD_OCT) ? SFX_F : SFX_NONE;
            default:  sl = SFX_NONE;
        endcase

        is_dec = char_reg >= "0" && char_reg <= "9";
        is_lo  = char_reg >= "a" && char_reg <= "f";
        is_up  = char_reg >= "A" && char_reg <= "F";
        if (is_dec)
            dval = 4'(char_reg - "0");
        else if (is_lo)
            dval = 4'(char_reg - "a" + 8'd10);
        else
            dval = 4'(char_reg - "A" + 8'd10);

        case (radix_next)
            RAD_DEC: dig_ok = is_dec;
            RAD_HEX: dig_ok = is_dec || is_lo || is_up;
            RAD_BIN: dig_ok = char_reg == "0" || char_reg == "1";
            default: dig_ok = char_reg >= "0" && char_reg <= "7";
        endcase

        if (!malf_reg)
        begin
            if (phase_next == PH_SUFFIX)
            begin
                if (is_dec && sdig_reg != BAD_DIGITS && scount_reg < 2'd3)
                begin
                    sdig_next   = 10'((sdig_reg << 3) + (sdig_reg << 1) + 10'(dval));
                    scount_next = scount_reg + 2'd1;
                end
                else
                begin
                    sdig_next = BAD_DIGITS;
                end
            end
            else if (phase_next == PH_AFTER_SPEC)
            begin
                if (sl != SFX_NONE)
                begin
                    letter_next = sl;
                    phase_next  = PH_SUFFIX;
                end
                else
                begin
                    malf_next = 1'b1;
                end
            end
            else
            begin
                is_c = 1'b0;
                // a pending b or o spec is resolved by this character
                if (specp_reg)
                begin
                    specp_next = 1'b0;
                    if (sl != SFX_NONE)
                    begin
                        specs_next  = 1'b1;
                        letter_next = sl;
                        phase_next  = PH_SUFFIX;
                        is_c        = 1'b1;
                    end
                    else if (raw_reg == 8'd1 && fz_reg && !prefix_reg)
                    begin
                        prefix_next = 1'b1;
                        acc_next    = '0;
                        ovf_next    = 1'b0;
                        raw_next    = 8'd0;
                        fz_next     = 1'b0;
                    end
                    else
                    begin
                        malf_next = 1'b1;
                        is_c      = 1'b1;
                    end
                end

                if (!is_c)
                begin
                    if (sl != SFX_NONE)
                    begin
                        if (raw_next == 8'd0)
                            malf_next = 1'b1;
                        else
                        begin
                            letter_next = sl;
                            phase_next  = PH_SUFFIX;
                        end
                    end
                    else if (dig_ok || char_reg == "_")
                    begin
                        if (raw_next == 8'd0)
                            fz_next = (char_reg == "0");
                        if (raw_next != 8'd255)
                            raw_next = raw_next + 8'd1;
                        if (dig_ok && !ovf_next)
                        begin
                            case (radix_next)
                                RAD_DEC: wide = (WIDE_BITS'(acc_next) << 3)
                                              + (WIDE_BITS'(acc_next) << 1);
                                RAD_HEX: wide = WIDE_BITS'(acc_next) << 4;
                                RAD_BIN: wide = WIDE_BITS'(acc_next) << 1;
                                default: wide = WIDE_BITS'(acc_next) << 3;
                            endcase
                            wide = wide + WIDE_BITS'(dval);
                            if (wide > WIDE_BITS'(MASK))
                                ovf_next = 1'b1;
                            else
                                acc_next = VALUE_BITS'(wide);
                        end
                    end
                    else if (radix_next == RAD_HEX && (char_reg == "x" || char_reg == "X"))
                    begin
                        if (raw_next == 8'd1 && fz_next && !prefix_next)
                        begin
                            prefix_next = 1'b1;
                            acc_next    = '0;
                            ovf_next    = 1'b0;
                            raw_next    = 8'd0;
                            fz_next     = 1'b0;
                        end
                        else
                        begin
                            malf_next = 1'b1;
                        end
                    end
                    else if (radix_next == RAD_HEX && (char_reg == "h" || char_reg == "H"))
                    begin
                        if (raw_next == 8'd0 || prefix_next)
                            malf_next = 1'b1;
                        else
                        begin
                            specs_next = 1'b1;
                            phase_next = PH_AFTER_SPEC;
                        end
                    end
                    else if ((radix_next == RAD_BIN && (char_reg == "b" || char_reg == "B"))
                          || (radix_next == RAD_OCT && (char_reg == "o" || char_reg == "O")))
                    begin
                        if (raw_next == 8'd0)
                            malf_next = 1'b1;
                        else
                            specp_next = 1'b1;
                    end
                    else
                    begin
                        malf_next = 1'b1;
                    end
                end
            end
        end
    end

    // end of token: suffix decode and checks
    logic [2:0] widx;
    logic       sfx_bad;
    logic       spec_any;

    always_comb
    begin
        widx    = W_NONE;
        sfx_bad = 1'b0;
        if (letter_next != SFX_NONE)
        begin
            if (sdig_next == BAD_DIGITS)
                sfx_bad = 1'b1;
            else if (scount_next == 2'd0)
                widx = W_32;
            else if (scount_next == 2'd1 && sdig_next == 10'd8)
                widx = W_8;
            else if (scount_next == 2'd2 && sdig_next == 10'd16)
                widx = W_16;
            else if (scount_next == 2'd2 && sdig_next == 10'd32)
                widx = W_32;
            else if (scount_next == 2'd2 && sdig_next == 10'd64)
                widx = W_64;
            else if (scount_next == 2'd3 && sdig_next == 10'd128)
                widx = W_128;
            else if (scount_next == 2'd3 && sdig_next == 10'd256)
                widx = W_256;
            else if (scount_next == 2'd3 && sdig_next == 10'd512)
                widx = W_512;
            else
                sfx_bad = 1'b1;
            if (!sfx_bad && letter_next == SFX_F && widx != W_32 && widx != W_64)
                sfx_bad = 1'b1;
            if (sfx_bad)
                widx = W_NONE;
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        type_next   = TY_I32;
        spec_any    = specs_next || specp_next;

        if (malf_next || raw_next == 8'd0
            || (radix_next != RAD_DEC && !prefix_next && !spec_any))
            status_next = ST_MALFORMED;
        else if (sfx_bad)
            status_next = ST_BAD_SFX;
        else if (10'(raw_next) > len_limit(radix_next, widx) || raw_next >= limit_reg)
            status_next = ST_TOO_LONG;
        else if (letter_next == SFX_NONE || letter_next == SFX_I)
        begin
            if (ovf_next || acc_next > SMAX)
                status_next = ST_OVERFLOW;
            else if (letter_next == SFX_NONE)
                type_next = (acc_next > acc_t'(32'h7FFF_FFFF)) ? TY_I64 : TY_I32;
            else
            begin
                case (widx)
                    W_8:
                    begin
                        if (acc_next > acc_t'(127)) status_next = ST_OVERFLOW;
                        else type_next = TY_I8;
                    end
                    W_16:
                    begin
                        if (acc_next > acc_t'(32767)) status_next = ST_OVERFLOW;
                        else type_next = TY_I16;
                    end
                    W_32:
                    begin
                        if (acc_next > acc_t'(32'h7FFF_FFFF)) status_next = ST_OVERFLOW;
                        else type_next = TY_I32;
                    end
                    W_64:    type_next = TY_I64;
                    default: status_next = ST_NOT_IMPL;
                endcase
            end
        end
        else if (letter_next == SFX_U)
        begin
            if (ovf_next)
                status_next = ST_OVERFLOW;
            else
            begin
                case (widx)
                    W_8:
                    begin
                        if (acc_next > acc_t'(255)) status_next = ST_OVERFLOW;
                        else type_next = TY_U8;
                    end
                    W_16:
                    begin
                        if (acc_next > acc_t'(65535)) status_next = ST_OVERFLOW;
                        else type_next = TY_U16;
                    end
                    W_32:
                    begin
                        if (acc_next > acc_t'(32'hFFFF_FFFF)) status_next = ST_OVERFLOW;
                        else type_next = TY_U32;
                    end
                    W_64:    type_next = TY_U64;
                    default: status_next = ST_NOT_IMPL;
                endcase
            end
        end
        else
        begin
            if (ovf_next)
                status_next = ST_OVERFLOW;
            else if (widx == W_32)
            begin
                if (acc_next > acc_t'(32'hFFFF_FFFF)) status_next = ST_OVERFLOW;
                else type_next = TY_F32;
            end
            else
                type_next = TY_F64;
        end

        if (status_next != ST_OK)
        begin
            type_next  = TY_I32;
            value_next = '0;
        end
        else
        begin
            value_next = OUT_BITS'(acc_next);
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg   <= character;
            rad_in_reg <= radix_class;
            last_reg   <= last_char;
        end
    end

    // token state, cleared after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            acc_reg    <= '0;
            ovf_reg    <= 1'b0;
            raw_reg    <= 8'd0;
            fz_reg     <= 1'b0;
            prefix_reg <= 1'b0;
            specp_reg  <= 1'b0;
            specs_reg  <= 1'b0;
            letter_reg <= SFX_NONE;
            sdig_reg   <= 10'd0;
            scount_reg <= 2'd0;
            malf_reg   <= 1'b0;
            radix_reg  <= RAD_DEC;
        end
        else if (advance && last_reg)
        begin
            phase_reg  <= PH_START;
            acc_reg    <= '0;
            ovf_reg    <= 1'b0;
            raw_reg    <= 8'd0;
            fz_reg     <= 1'b0;
            prefix_reg <= 1'b0;
            specp_reg  <= 1'b0;
            specs_reg  <= 1'b0;
            letter_reg <= SFX_NONE;
            sdig_reg   <= 10'd0;
            scount_reg <= 2'd0;
            malf_reg   <= 1'b0;
            radix_reg  <= RAD_DEC;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            ovf_reg    <= ovf_next;
            raw_reg    <= raw_next;
            fz_reg     <= fz_next;
            prefix_reg <= prefix_next;
            specp_reg  <= specp_next;
            specs_reg  <= specs_next;
            letter_reg <= letter_next;
            sdig_reg   <= sdig_next;
            scount_reg <= scount_next;
            malf_reg   <= malf_next;
            radix_reg  <= radix_next;
        end
    end

    // length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= value_length_limit;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            value_reg  <= value_next;
            type_reg   <= type_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign type_code = type_reg;
    assign status    = status_reg;

endmodule

[dv/integer_literal_parser_tb.sv]
// testbench for integer_literal_parser: token traffic checked against a local predictor
module integer_literal_parser_tb
    import ilp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDLE_LIMIT = 2000;
    localparam logic [63:0] ALL_ONES   = '1;
    localparam logic [63:0] SIGNED_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] I32_MAX    = 64'h7FFF_FFFF;
    localparam logic [63:0] U32_MAX    = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [63:0] value;
        logic [3:0]  type_code;
        logic [2:0]  status;
    } literal_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  character;
    logic [1:0]  radix_class;
    logic        last_char;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] value;
    logic [3:0]  type_code;
    logic [2:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  value_length_limit;

    // token state of the predictor
    logic [1:0]  tk_phase;
    logic [1:0]  tk_radix;
    logic [1:0]  tk_sfx;
    logic [63:0] tk_acc;
    logic        tk_ovf;
    logic        tk_zero_first;
    logic        tk_prefix;
    logic        tk_spec_pend;
    logic        tk_spec;
    logic        tk_bad;
    logic [9:0]  tk_sfx_val;
    int unsigned tk_raw;
    int unsigned tk_sfx_cnt;
    logic [7:0]  len_cap;

    int unsigned raw_cap [4][8] = '{
        '{3, 5, 10, 20, 39, 78, 155, 20},
        '{2, 4, 8, 16, 32, 64, 128, 16},
        '{8, 16, 32, 64, 128, 256, 512, 64},
        '{3, 8, 11, 22, 22, 22, 22, 22}
    };

    literal_t   expected_literals[$];
    logic [7:0] tok_chars[$];

    int gap_max;
    int stall_max;
    int n_chars;
    int n_tokens;
    int n_results;
    int n_errors;
    int idle_cycles;
    int status_seen [8];

    integer_literal_parser u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] radix_base(input logic [1:0] rad);
        case (rad)
            RAD_DEC: return 64'd10;
            RAD_HEX: return 64'd16;
            RAD_BIN: return 64'd2;
            default: return 64'd8;
        endcase
    endfunction

    function automatic logic [1:0] letter_of(input logic [7:0] c, input logic [1:0] rad);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
        if (lc == "i") return SFX_I;
        if (lc == "u") return SFX_U;
        if (rad == RAD_HEX && lc == "p") return SFX_F;
        if ((rad == RAD_BIN || rad == RAD_OCT) && lc == "f") return SFX_F;
        return SFX_NONE;
    endfunction

    function automatic int digit_val(input logic [7:0] c, input logic [1:0] rad);
        int d;
        d = -1;
        if (c >= "0" && c <= "9") d = int'(c) - int'("0");
        else if (c >= "a" && c <= "f") d = int'(c) - int'("a") + 10;
        else if (c >= "A" && c <= "F") d = int'(c) - int'("A") + 10;
        if (rad == RAD_DEC && d > 9) d = -1;
        if (rad == RAD_BIN && d > 1) d = -1;
        if (rad == RAD_OCT && d > 7) d = -1;
        return d;
    endfunction

    function automatic void clear_token();
        tk_phase      = PH_START;
        tk_radix      = RAD_DEC;
        tk_sfx        = SFX_NONE;
        tk_acc        = '0;
        tk_ovf        = 1'b0;
        tk_zero_first = 1'b0;
        tk_prefix     = 1'b0;
        tk_spec_pend  = 1'b0;
        tk_spec       = 1'b0;
        tk_bad        = 1'b0;
        tk_sfx_val    = '0;
        tk_raw        = 0;
        tk_sfx_cnt    = 0;
    endfunction

    // a lone leading zero turns into a prefix: value restarts
    function automatic void take_prefix();
        if (tk_raw == 1 && tk_zero_first && !tk_prefix)
        begin
            tk_prefix     = 1'b1;
            tk_acc        = '0;
            tk_ovf        = 1'b0;
            tk_raw        = 0;
            tk_zero_first = 1'b0;
        end
        else
        begin
            tk_bad = 1'b1;
        end
    endfunction

    function automatic void count_raw(input logic [7:0] c);
        if (tk_raw == 0) tk_zero_first = (c == "0");
        if (tk_raw < 255) tk_raw++;
    endfunction

    function automatic void feed_char(input logic [7:0] c, input logic [1:0] rad);
        logic [1:0]  sl;
        logic [63:0] base;
        int          d;
        sl = letter_of(c, rad);
        base = radix_base(rad);
        if (tk_phase == PH_SUFFIX)
        begin
            if (c >= "0" && c <= "9" && tk_sfx_val != BAD_DIGITS && tk_sfx_cnt < 3)
            begin
                tk_sfx_val = 10'(tk_sfx_val * 10 + (int'(c) - int'("0")));
                tk_sfx_cnt++;
            end
            else
            begin
                tk_sfx_val = BAD_DIGITS;
            end
            return;
        end
        if (tk_phase == PH_AFTER_SPEC)
        begin
            if (sl != SFX_NONE) begin tk_sfx = sl; tk_phase = PH_SUFFIX; end
            else tk_bad = 1'b1;
            return;
        end
        // trailing b/o followed by more: either a suffix or it was a prefix
        if (tk_spec_pend)
        begin
            tk_spec_pend = 1'b0;
            if (sl != SFX_NONE)
            begin
                tk_spec  = 1'b1;
                tk_sfx   = sl;
                tk_phase = PH_SUFFIX;
                return;
            end
            take_prefix();
            if (tk_bad) return;
        end
        if (sl != SFX_NONE)
        begin
            if (tk_raw == 0) tk_bad = 1'b1;
            else begin tk_sfx = sl; tk_phase = PH_SUFFIX; end
            return;
        end
        d = digit_val(c, rad);
        if (d >= 0)
        begin
            count_raw(c);
            if (!tk_ovf)
            begin
                if (tk_acc > (ALL_ONES - 64'(d)) / base) tk_ovf = 1'b1;
                else tk_acc = tk_acc * base + 64'(d);
            end
            return;
        end
        if (c == "_")
        begin
            count_raw(c);
            return;
        end
        if (rad == RAD_HEX && (c == "x" || c == "X"))
        begin
            take_prefix();
            return;
        end
        if (rad == RAD_HEX && (c == "h" || c == "H"))
        begin
            if (tk_raw == 0 || tk_prefix) tk_bad = 1'b1;
            else begin tk_spec = 1'b1; tk_phase = PH_AFTER_SPEC; end
            return;
        end
        if ((rad == RAD_BIN && (c == "b" || c == "B")) || (rad == RAD_OCT && (c == "o" || c == "O")))
        begin
            if (tk_raw == 0) tk_bad = 1'b1;
            else tk_spec_pend = 1'b1;
            return;
        end
        tk_bad = 1'b1;
    endfunction

    function automatic literal_t literal_result();
        literal_t   r;
        logic [2:0] widx;
        logic       sfx_ok;
        r.value     = '0;
        r.type_code = TY_I32;
        r.status    = ST_OK;
        widx        = W_NONE;
        sfx_ok      = 1'b1;
        if (tk_spec_pend) tk_spec = 1'b1;
        if (tk_sfx != SFX_NONE)
        begin
            if (tk_sfx_val == BAD_DIGITS) sfx_ok = 1'b0;
            else if (tk_sfx_cnt == 0) widx = W_32;
            else if (tk_sfx_cnt == 1 && tk_sfx_val == 10'd8) widx = W_8;
            else if (tk_sfx_cnt == 2 && tk_sfx_val == 10'd16) widx = W_16;
            else if (tk_sfx_cnt == 2 && tk_sfx_val == 10'd32) widx = W_32;
            else if (tk_sfx_cnt == 2 && tk_sfx_val == 10'd64) widx = W_64;
            else if (tk_sfx_cnt == 3 && tk_sfx_val == 10'd128) widx = W_128;
            else if (tk_sfx_cnt == 3 && tk_sfx_val == 10'd256) widx = W_256;
            else if (tk_sfx_cnt == 3 && tk_sfx_val == 10'd512) widx = W_512;
            else sfx_ok = 1'b0;
            if (tk_sfx == SFX_F && widx != W_32 && widx != W_64) sfx_ok = 1'b0;
        end
        if (tk_bad || tk_raw == 0 || (tk_radix != RAD_DEC && !tk_prefix && !tk_spec))
            r.status = ST_MALFORMED;
        else if (!sfx_ok)
            r.status = ST_BAD_SFX;
        else if (tk_raw > raw_cap[tk_radix][widx] || tk_raw >= len_cap)
            r.status = ST_TOO_LONG;
        else if (tk_ovf)
            r.status = ST_OVERFLOW;
        else if (tk_sfx == SFX_NONE || tk_sfx == SFX_I)
        begin
            if (tk_acc > SIGNED_MAX) r.status = ST_OVERFLOW;
            else
            begin
                case (widx)
                    W_NONE: r.type_code = (tk_acc > I32_MAX) ? TY_I64 : TY_I32;
                    W_8:    if (tk_acc > 64'd127) r.status = ST_OVERFLOW; else r.type_code = TY_I8;
                    W_16:   if (tk_acc > 64'd32767) r.status = ST_OVERFLOW; else r.type_code = TY_I16;
                    W_32:   if (tk_acc > I32_MAX) r.status = ST_OVERFLOW; else r.type_code = TY_I32;
                    W_64:   r.type_code = TY_I64;
                    default: r.status = ST_NOT_IMPL;
                endcase
            end
        end
        else if (tk_sfx == SFX_U)
        begin
            case (widx)
                W_8:     if (tk_acc > 64'd255) r.status = ST_OVERFLOW; else r.type_code = TY_U8;
                W_16:    if (tk_acc > 64'd65535) r.status = ST_OVERFLOW; else r.type_code = TY_U16;
                W_32:    if (tk_acc > U32_MAX) r.status = ST_OVERFLOW; else r.type_code = TY_U32;
                W_64:    r.type_code = TY_U64;
                default: r.status = ST_NOT_IMPL;
            endcase
        end
        else if (widx == W_32)
        begin
            if (tk_acc > U32_MAX) r.status = ST_OVERFLOW; else r.type_code = TY_F32;
        end
        else
        begin
            r.type_code = TY_F64;
        end
        if (r.status == ST_OK) r.value = tk_acc;
        else r.type_code = TY_I32;
        return r;
    endfunction

    // called on every accepted character
    function automatic void track_literal_char(input logic [7:0] c, input logic [1:0] r,
                                               input logic l);
        if (tk_phase == PH_START)
        begin
            tk_radix = r;
            tk_phase = PH_VALUE;
        end
        if (!tk_bad) feed_char(c, tk_radix);
        if (l)
        begin
            expected_literals.push_back(literal_result());
            clear_token();
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic [1:0] r, input logic l);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        character   <= c;
        radix_class <= r;
        last_char   <= l;
        do @(posedge clk); while (in_stall !== 1'b0);
        track_literal_char(c, r, l);
        n_chars++;
    endtask

    // later radix_class values of a token are random when wobble is set
    task automatic send_token(input logic [1:0] rad, input bit wobble);
        logic [1:0] r;
        for (int i = 0; i < tok_chars.size(); i++)
        begin
            r = (i == 0 || !wobble) ? rad : 2'($urandom_range(0, 3));
            send_char(tok_chars[i], r, i == tok_chars.size() - 1);
        end
        n_tokens++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) tok_chars.push_back(s[i]);
    endtask

    task automatic send_text(input string s, input logic [1:0] rad);
        tok_chars.delete();
        push_text(s);
        send_token(rad, 1'b0);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_literals.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length_limit(input logic [7:0] lim);
        drain_results();
        cfg_valid          <= 1'b1;
        value_length_limit <= lim;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        len_cap = lim;
    endtask

    // well-formed token with random content; broken ones get one mutation
    task automatic build_token(input logic [1:0] rad, input bit broken);
        int          n;
        int          pick;
        bit          use_prefix;
        logic [63:0] bound;
        logic [63:0] v;
        logic [7:0]  c;
        string       s;
        tok_chars.delete();
        use_prefix = (rad != RAD_DEC) && ($urandom_range(0, 1) == 1);
        if (use_prefix)
        begin
            tok_chars.push_back("0");
            case (rad)
                RAD_HEX: c = "x";
                RAD_BIN: c = "b";
                default: c = "o";
            endcase
            tok_chars.push_back($urandom_range(0, 1) ? c : c ^ 8'h20);
        end
        pick = $urandom_range(0, 9);
        if (pick == 9)
        begin
            // values at and next to the type range edges
            case ($urandom_range(0, 7))
                0: bound = 64'h7F;
                1: bound = 64'hFF;
                2: bound = 64'h7FFF;
                3: bound = 64'hFFFF;
                4: bound = I32_MAX;
                5: bound = U32_MAX;
                6: bound = SIGNED_MAX;
                default: bound = ALL_ONES;
            endcase
            bound = bound + 64'($urandom_range(0, 2)) - 64'd1;
            case (rad)
                RAD_DEC: s = $sformatf("%0d", bound);
                RAD_HEX: s = $sformatf("%0h", bound);
                RAD_BIN: s = $sformatf("%0b", bound);
                default: s = $sformatf("%0o", bound);
            endcase
            push_text(s);
        end
        else
        begin
            if (pick < 6) n = $urandom_range(1, 4);
            else if (pick < 8) n = $urandom_range(5, 12);
            else
            begin
                case (rad)
                    RAD_DEC: n = $urandom_range(13, 22);
                    RAD_HEX: n = $urandom_range(13, 18);
                    RAD_BIN: n = $urandom_range(13, 66);
                    default: n = $urandom_range(13, 24);
                endcase
            end
            repeat (n)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    tok_chars.push_back("_");
                end
                else
                begin
                    v = 64'($urandom_range(0, int'(radix_base(rad)) - 1));
                    if (v < 10) c = 8'("0" + v);
                    else c = 8'("a" + v - 10);
                    tok_chars.push_back((c >= "a" && $urandom_range(0, 1)) ? c ^ 8'h20 : c);
                end
            end
        end
        if (rad != RAD_DEC && !use_prefix)
        begin
            case (rad)
                RAD_HEX: c = "h";
                RAD_BIN: c = "b";
                default: c = "o";
            endcase
            tok_chars.push_back($urandom_range(0, 1) ? c : c ^ 8'h20);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            case ($urandom_range(0, 2))
                0: c = "i";
                1: c = "u";
                default: c = (rad == RAD_HEX) ? "p" : "f";
            endcase
            tok_chars.push_back($urandom_range(0, 1) ? c : c ^ 8'h20);
            case ($urandom_range(0, 13))
                0, 1:    s = "";
                2:       s = "8";
                3:       s = "16";
                4, 5:    s = "32";
                6, 7:    s = "64";
                8:       s = "128";
                9:       s = "256";
                10:      s = "512";
                11:      s = "7";
                12:      s = "032";
                default: s = "1024";
            endcase
            push_text(s);
        end
        if (broken)
        begin
            n = $urandom_range(0, tok_chars.size() - 1);
            s = "_xXhHbBoO0iu";
            case ($urandom_range(0, 3))
                0: tok_chars[n] = 8'($urandom_range(0, 255));
                1: tok_chars.insert(n, 8'($urandom_range(0, 255)));
                2: while (tok_chars.size() > n + 1) void'(tok_chars.pop_back());
                default: tok_chars.insert(n, s[$urandom_range(0, s.len() - 1)]);
            endcase
        end
    endtask

    task automatic send_random_token();
        logic [1:0] rad;
        rad = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0)
        begin
            tok_chars.delete();
            repeat ($urandom_range(1, 6)) tok_chars.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            build_token(rad, $urandom_range(0, 4) == 0);
        end
        send_token(rad, $urandom_range(0, 3) == 0);
    endtask

    task automatic test_directed_literals();
        send_text("0", RAD_DEC);
        send_text("127i8", RAD_DEC);
        send_text("128i8", RAD_DEC);
        send_text("256u8", RAD_DEC);
        send_text("65536u16", RAD_DEC);
        send_text("2147483648", RAD_DEC);
        send_text("9223372036854775808", RAD_DEC);
        send_text("18446744073709551615u64", RAD_DEC);
        send_text("18446744073709551616u64", RAD_DEC);
        send_text("1_000", RAD_DEC);
        send_text("7i128", RAD_DEC);
        send_text("1u7", RAD_DEC);
        send_text("12a", RAD_DEC);
        send_text("i", RAD_DEC);
        send_text("0xFFp32", RAD_HEX);
        send_text("0x", RAD_HEX);
        send_text("ffh", RAD_HEX);
        send_text("ff", RAD_HEX);
        send_text("0x0x1", RAD_HEX);
        send_text("1Hu16", RAD_HEX);
        send_text("0bi", RAD_BIN);
        send_text("101b", RAD_BIN);
        send_text("1f64", RAD_BIN);
        send_text("0o777", RAD_OCT);
        send_text("17O", RAD_OCT);
        // character code extremes
        tok_chars.delete();
        tok_chars.push_back(8'h00);
        tok_chars.push_back(8'hFF);
        send_token(RAD_DEC, 1'b0);
        // radix class changing inside a token
        tok_chars.delete();
        push_text("0x1f");
        send_token(RAD_HEX, 1'b1);
        drain_results();
    endtask

    task automatic test_length_limit();
        logic [7:0] lims [6];
        lims = '{8'd1, 8'd0, 8'd2, 8'd6, 8'($urandom_range(3, 254)), LIMIT_RESET};
        foreach (lims[i])
        begin
            write_length_limit(lims[i]);
            repeat (10) send_random_token();
        end
        drain_results();
    endtask

    task automatic test_random_literals(input int chars_target, input int gmax, input int smax);
        int start;
        int k;
        gap_max   = gmax;
        stall_max = smax;
        start     = n_chars;
        k         = 0;
        while (n_chars - start < chars_target)
        begin
            send_random_token();
            k++;
            // hold off now and then until every result is back
            if (k % 40 == 0) drain_results();
        end
        drain_results();
    endtask

    // result side: random stall per request, then compare with the oldest prediction
    initial
    begin
        literal_t exp_lit;
        int       n;
        wait (rst_n === 1'b1);
        forever
        begin
            n = $urandom_range(0, stall_max);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            n_results++;
            status_seen[status]++;
            if (expected_literals.size() == 0)
            begin
                $error("result with no request pending: value %h type %0d status %0d",
                       value, type_code, status);
                n_errors++;
            end
            else
            begin
                exp_lit = expected_literals.pop_front();
                if (value !== exp_lit.value)
                begin
                    $error("value: expected %h, got %h", exp_lit.value, value);
                    n_errors++;
                end
                if (type_code !== exp_lit.type_code)
                begin
                    $error("type_code: expected %0d, got %0d", exp_lit.type_code, type_code);
                    n_errors++;
                end
                if (status !== exp_lit.status)
                begin
                    $error("status: expected %0d, got %0d", exp_lit.status, status);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        in_valid           <= 1'b0;
        character          <= '0;
        radix_class        <= RAD_DEC;
        last_char          <= 1'b0;
        out_stall          <= 1'b0;
        cfg_valid          <= 1'b0;
        value_length_limit <= LIMIT_RESET;
        idle_cycles        = 0;
        n_chars            = 0;
        n_tokens           = 0;
        n_results          = 0;
        n_errors           = 0;
        gap_max            = 11;
        stall_max          = 11;
        foreach (status_seen[i]) status_seen[i] = 0;
        len_cap = LIMIT_RESET;
        clear_token();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_literals();
        test_length_limit();
        test_random_literals(300, 11, 11);
        test_random_literals(150, 0, 0);
        test_random_literals(150, 0, 11);
        test_random_literals(150, 11, 0);

        in_valid  <= 1'b0;
        stall_max = 0;
        while (expected_literals.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("ran %0d characters in %0d tokens, %0d results checked, %0d mismatches",
                 n_chars, n_tokens, n_results, n_errors);
        $display("status mix: ok %0d, bad suffix %0d, too long %0d, overflow %0d, %s %0d, %s %0d",
                 status_seen[ST_OK], status_seen[ST_BAD_SFX], status_seen[ST_TOO_LONG],
                 status_seen[ST_OVERFLOW], "not implemented", status_seen[ST_NOT_IMPL],
                 "malformed", status_seen[ST_MALFORMED]);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
